>>> design/assert_macros.svh
// Assertion macros for the checker file salc_checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> design/salc_pkg.sv
// Types and constants of the cache tag and replacement unit.
// No dependencies.
package salc_pkg;
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_ALLOCATE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PREFETCH_MODE  = 1'd1;
    localparam logic [1:0] PF_NONE   = 2'd0;
    localparam logic [1:0] PF_BEFORE = 2'd1;
    localparam logic [1:0] PF_AFTER  = 2'd2;

    typedef struct packed {
        logic hit;
        logic filled;
    } t_lookup_res;
endpackage

>>> design/salc_set_mem.sv
// Set memory: valid bits, tags and recency ranks of all ways of one set per row.
// Depends on salc_pkg. One read and one write port, registered read.
module salc_set_mem #(
    parameter int unsigned WAYS   = 4,
    parameter int unsigned SETS   = 128,
    parameter int unsigned TAG_W  = 20,
    parameter int unsigned RANK_W = 2,
    parameter int unsigned SET_W  = 7
) (
    input  logic                           i_clk,
    input  logic [SET_W-1:0]               i_rd_set,
    input  logic                           i_wr_en,
    input  logic [SET_W-1:0]               i_wr_set,
    input  logic [WAYS-1:0]                i_wr_valid,
    input  logic [WAYS-1:0][TAG_W-1:0]     i_wr_tag,
    input  logic [WAYS-1:0][RANK_W-1:0]    i_wr_rank,
    output logic [WAYS-1:0]                o_rd_valid,
    output logic [WAYS-1:0][TAG_W-1:0]     o_rd_tag,
    output logic [WAYS-1:0][RANK_W-1:0]    o_rd_rank
);
    import salc_pkg::*;

    logic [WAYS-1:0][TAG_W-1:0]  r_tag_mem  [SETS];
    logic [WAYS-1:0][RANK_W-1:0] r_rank_mem [SETS];
    logic [WAYS-1:0]             r_vld_mem  [SETS];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_tag_mem[i_wr_set]  <= i_wr_tag;
            r_rank_mem[i_wr_set] <= i_wr_rank;
            r_vld_mem[i_wr_set]  <= i_wr_valid;
        end
        o_rd_tag   <= r_tag_mem[i_rd_set];
        o_rd_rank  <= r_rank_mem[i_rd_set];
        o_rd_valid <= r_vld_mem[i_rd_set];
    end
endmodule

>>> design/salc_update.sv
// Hit check, victim choice and LRU rank update for one set row.
// Depends on salc_pkg.
module salc_update #(
    parameter int unsigned WAYS   = 4,
    parameter int unsigned TAG_W  = 20,
    parameter int unsigned RANK_W = 2
) (
    input  logic [WAYS-1:0]                i_valid,
    input  logic [WAYS-1:0][TAG_W-1:0]     i_tag,
    input  logic [WAYS-1:0][RANK_W-1:0]    i_rank,
    input  logic [TAG_W-1:0]               i_look_tag,
    input  logic                           i_may_fill,
    output logic                           o_write,
    output logic [WAYS-1:0]                o_valid,
    output logic [WAYS-1:0][TAG_W-1:0]     o_tag,
    output logic [WAYS-1:0][RANK_W-1:0]    o_rank,
    output salc_pkg::t_lookup_res          o_res
);
    import salc_pkg::*;

    localparam logic [RANK_W-1:0] LAST_RANK = RANK_W'(WAYS - 1);

    logic [WAYS-1:0] hit_vec;
    logic [WAYS-1:0] inv_sel;
    logic [WAYS-1:0] lru_sel;
    logic [WAYS-1:0] tgt;
    logic [RANK_W-1:0] old_rank;
    logic any_inv;

    always_comb begin
        any_inv = 1'b0;
        inv_sel = '0;
        lru_sel = '0;
        for (int w = 0; w < WAYS; w++) begin
            hit_vec[w] = i_valid[w] && (i_tag[w] == i_look_tag);
            if (!i_valid[w] && !any_inv) begin
                inv_sel[w] = 1'b1;
                any_inv    = 1'b1;
            end
            lru_sel[w] = (i_rank[w] == LAST_RANK);
        end
        o_res.hit    = |hit_vec;
        o_res.filled = !(|hit_vec) && i_may_fill;
        o_write      = o_res.hit || o_res.filled;
        tgt = o_res.hit ? hit_vec : (any_inv ? inv_sel : lru_sel);
        old_rank = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (tgt[w]) old_rank = old_rank | i_rank[w];
        end
        for (int w = 0; w < WAYS; w++) begin
            o_valid[w] = i_valid[w] | (tgt[w] & o_res.filled);
            o_tag[w]   = (tgt[w] && o_res.filled) ? i_look_tag : i_tag[w];
            if (tgt[w])
                o_rank[w] = '0;
            else if (i_rank[w] < old_rank)
                o_rank[w] = i_rank[w] + 1'b1;
            else
                o_rank[w] = i_rank[w];
        end
    end
endmodule

>>> design/set_assoc_lru_cache_tag_unit_core.sv
// Tag and replacement unit of a set-associative cache with true LRU.
// A lookup passes ST_READ (set address), ST_WAIT (memory read) and ST_MOD (check and write
// back); an access runs through accept, one lookup and result, or through two lookups when a
// prefetch lookup comes before the demand lookup or, on a demand miss, after it. The
// read-modify-write of a set memory row sets the length of a lookup; a result held by a
// stalled receiver stalls the input. After reset a clearing pass over all SETS rows initialises
// the set memory before the first access. Depends on salc_pkg, salc_set_mem and salc_update.
module set_assoc_lru_cache_tag_unit_core #(
    parameter int unsigned WAYS            = 4,
    parameter int unsigned SETS            = 128,
    parameter int unsigned LINE_BYTES_LOG2 = 5,
    parameter int unsigned ADDRESS_BITS    = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [((ADDRESS_BITS+8)/8)*8-1:0] s_axis_tdata,  // byte_address, is_store
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [7:0]                        m_axis_tdata,  // hit, allocated
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [salc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [1:0]                        i_cfg_data
);
    import salc_pkg::*;

    localparam int unsigned SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int unsigned SET_B  = $clog2(SETS);
    localparam int unsigned RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int unsigned LINE_W = ADDRESS_BITS - LINE_BYTES_LOG2;
    localparam int unsigned TAG_W  = (LINE_W > SET_B) ? LINE_W - SET_B : 1;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_WAIT, ST_MOD, ST_OUT
    } t_state;

    t_state r_state;
    logic [SET_W-1:0]  r_clr;
    logic              r_wa;
    logic [1:0]        r_pf;
    logic [LINE_W-1:0] r_line;
    logic              r_store;
    logic [1:0]        r_phase;
    logic [LINE_W-1:0] r_cur;
    logic              r_cur_fill;
    logic              r_hit;
    logic              r_alloc;

    logic [WAYS-1:0]             rd_valid, up_valid;
    logic [WAYS-1:0][TAG_W-1:0]  rd_tag, up_tag;
    logic [WAYS-1:0][RANK_W-1:0] rd_rank, up_rank, clr_rank;
    logic                        up_write;
    t_lookup_res                 up_res;
    logic [SET_W-1:0]            cur_set;
    logic [TAG_W-1:0]            cur_tag;
    logic                        wr_en;
    logic [SET_W-1:0]            wr_set;
    logic [WAYS-1:0]             wr_valid;
    logic [WAYS-1:0][RANK_W-1:0] wr_rank;
    logic [LINE_W-1:0]           in_line;
    logic                        may_fill;

    always_comb begin
        for (int w = 0; w < WAYS; w++) clr_rank[w] = RANK_W'(w);
        if (SET_B == 0) cur_set = '0;
        else cur_set = SET_W'(r_cur);
        cur_tag  = TAG_W'(r_cur >> SET_B);
        in_line  = s_axis_tdata[ADDRESS_BITS-1:LINE_BYTES_LOG2];
        may_fill = !(r_store && !r_wa);
        wr_en    = (r_state == ST_CLEAR) || ((r_state == ST_MOD) && up_write);
        wr_set   = (r_state == ST_CLEAR) ? r_clr : cur_set;
        wr_valid = (r_state == ST_CLEAR) ? '0 : up_valid;
        wr_rank  = (r_state == ST_CLEAR) ? clr_rank : up_rank;
    end

    salc_set_mem #(
        .WAYS(WAYS), .SETS(SETS), .TAG_W(TAG_W), .RANK_W(RANK_W), .SET_W(SET_W)
    ) u_mem (
        .i_clk(i_clk), .i_rd_set(cur_set), .i_wr_en(wr_en), .i_wr_set(wr_set),
        .i_wr_valid(wr_valid), .i_wr_tag(up_tag), .i_wr_rank(wr_rank),
        .o_rd_valid(rd_valid), .o_rd_tag(rd_tag), .o_rd_rank(rd_rank)
    );

    salc_update #(.WAYS(WAYS), .TAG_W(TAG_W), .RANK_W(RANK_W)) u_upd (
        .i_valid(rd_valid), .i_tag(rd_tag), .i_rank(rd_rank), .i_look_tag(cur_tag),
        .i_may_fill(r_cur_fill), .o_write(up_write), .o_valid(up_valid),
        .o_tag(up_tag), .o_rank(up_rank), .o_res(up_res)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = {6'd0, r_alloc, r_hit};

    // phase 0: prefetch before, 1: demand, 2: prefetch after
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_wa    <= 1'b1;
            r_pf    <= PF_NONE;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_WRITE_ALLOCATE: r_wa <= i_cfg_data[0];
                    REG_PREFETCH_MODE:  r_pf <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == SET_W'(SETS - 1)) r_state <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_line  <= in_line;
                        r_store <= s_axis_tdata[ADDRESS_BITS];
                        r_state <= ST_READ;
                        if (r_pf == PF_BEFORE) begin
                            r_phase    <= 2'd0;
                            r_cur      <= in_line + 1'b1;
                            r_cur_fill <= 1'b1;
                        end else begin
                            r_phase    <= 2'd1;
                            r_cur      <= in_line;
                            r_cur_fill <= !(s_axis_tdata[ADDRESS_BITS] && !r_wa);
                        end
                    end
                end
                ST_READ: r_state <= ST_WAIT;
                ST_WAIT: r_state <= ST_MOD;
                ST_MOD: begin
                    if (r_phase == 2'd0) begin
                        r_phase    <= 2'd1;
                        r_cur      <= r_line;
                        r_cur_fill <= may_fill;
                        r_state    <= ST_READ;
                    end else if (r_phase == 2'd1) begin
                        r_hit   <= up_res.hit;
                        r_alloc <= up_res.filled;
                        if (r_pf == PF_AFTER && !up_res.hit) begin
                            r_phase    <= 2'd2;
                            r_cur      <= r_line + 1'b1;
                            r_cur_fill <= 1'b1;
                            r_state    <= ST_READ;
                        end else begin
                            r_state <= ST_OUT;
                        end
                    end else begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: if (m_axis_tready) r_state <= ST_IDLE;
                default: r_state <= ST_CLEAR;
            endcase
        end
    end
endmodule

>>> design/salc_checker.sv
// Port-level checker for the cache tag unit, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module salc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);
    `ASSERT_IMPL(a_hit_no_alloc, i_clk, i_rst_n, m_axis_tvalid, !(m_axis_tdata[0] && m_axis_tdata[1]))
    `ASSERT_IMPL(a_one_side, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)
    `ASSERT_NEXT(a_no_quick_out, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !m_axis_tvalid)
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind set_assoc_lru_cache_tag_unit_core salc_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
